// ===== hdl/tsb_pkg.sv =====
// Shared types and constants for the terminal scrollback text buffer.
// Used by tsb_cell_ram and terminal_scrollback_text_buffer_core; no dependencies.
package tsb_pkg;

	// Default sizes
	localparam int MAX_COLUMNS_DEF     = 128;
	localparam int MAX_SCREEN_ROWS_DEF = 32;
	localparam int HISTORY_LINES_DEF   = 256;

	// Blank cell content and register reset values
	localparam logic [7:0]  BLANK_CHAR      = 8'h20;
	localparam logic [7:0]  COLUMNS_RESET   = 8'd128;
	localparam logic [5:0]  ROWS_RESET      = 6'd32;
	localparam logic [31:0] FOREGROUND_RESET = 32'h00FF_FFFF;
	localparam logic [31:0] BACKGROUND_RESET = 32'h0000_0000;
	localparam int          LINES_HELD_RESET = 32;

	// Command codes
	typedef enum logic [3:0] {
		OP_PUT       = 4'd0,
		OP_BACKSPACE = 4'd1,
		OP_NEWLINE   = 4'd2,
		OP_SETCURSOR = 4'd3,
		OP_CLRSCREEN = 4'd4,
		OP_CLRFROM   = 4'd5,
		OP_CLRTO     = 4'd6,
		OP_CLRLINE   = 4'd7,
		OP_SCROLL    = 4'd8,
		OP_READ      = 4'd9
	} tsb_op_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_COLUMNS    = 2'd0,
		CFG_ROWS       = 2'd1,
		CFG_FOREGROUND = 2'd2,
		CFG_BACKGROUND = 2'd3
	} tsb_cfg_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_NEWLINE,
		ST_FILL,
		ST_PUT,
		ST_CLS,
		ST_VIEW,
		ST_DONE
	} tsb_state_t;

	// One stored cell
	typedef struct packed {
		logic [31:0] bg;
		logic [31:0] fg;
		logic [7:0]  attr;
		logic [7:0]  ch;
	} tsb_cell_t;

endpackage

// ===== hdl/tsb_cell_ram.sv =====
// Cell store: one write port, one read port with registered read data.
// Depends on tsb_pkg for the cell type.
module tsb_cell_ram #(
	parameter int ADDR_W = 15
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  tsb_pkg::tsb_cell_t  wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output tsb_pkg::tsb_cell_t  rd_data
);

	tsb_pkg::tsb_cell_t mem [2**ADDR_W];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/terminal_scrollback_text_buffer_core.sv =====
// Terminal scrollback text buffer: cell ring with cursor, scrolling and view offset.
// Depends on tsb_pkg and tsb_cell_ram.
// Each item passes a decode state and a done state; a read adds a view state that reads the cell.
// A new line at the bottom row adds a fill of the recycled line; clears of a line run a fill as well.
// Clear screen fills each held line in turn; one cell per cycle.
// After reset a clearing pass writes all 2**ADDR_W cells of the RAM before the first item.
module terminal_scrollback_text_buffer_core #(
	parameter int MAX_COLUMNS     = tsb_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_SCREEN_ROWS = tsb_pkg::MAX_SCREEN_ROWS_DEF,
	parameter int HISTORY_LINES   = tsb_pkg::HISTORY_LINES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// command items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  op,
	input  logic [7:0]  char_code,
	input  logic [31:0] fore_colour,
	input  logic [31:0] back_colour,
	input  logic [7:0]  attr_flags,
	input  logic [6:0]  column_arg,
	input  logic [4:0]  row_arg,
	input  logic signed [9:0] scroll_delta,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  cell_char,
	output logic [31:0] cell_fore,
	output logic [31:0] cell_back,
	output logic [7:0]  cell_attr,
	output logic [7:0]  cursor_column,
	output logic [4:0]  cursor_line,
	output logic [7:0]  view_offset_out,
	// configuration writes
	input  logic        cfg_write_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int CC_W   = $clog2(MAX_COLUMNS + 1);
	localparam int ROW_W  = $clog2(MAX_SCREEN_ROWS);
	localparam int RC_W   = $clog2(MAX_SCREEN_ROWS + 1);
	localparam int LINE_W = $clog2(HISTORY_LINES);
	localparam int LH_W   = $clog2(HISTORY_LINES + 1);
	localparam int WW     = LINE_W + 2;
	localparam int SW     = ((LINE_W > 10) ? LINE_W : 10) + 2;
	localparam int ADDR_W = LINE_W + COL_W;

	// Ring index reduction; the operand is below twice the ring size
	function automatic logic [LINE_W-1:0] wrap_line(input logic [WW-1:0] v);
		if (v >= WW'(HISTORY_LINES)) begin
			return LINE_W'(v - WW'(HISTORY_LINES));
		end
		return LINE_W'(v);
	endfunction

	// Configuration registers
	logic [7:0]  columns_q;
	logic [5:0]  rows_q;
	logic [31:0] dfg_q;
	logic [31:0] dbg_q;

	// Control state
	tsb_pkg::tsb_state_t state_q, state_d, ret_q, ret_d;
	logic [CC_W-1:0]   cur_col_q, cur_col_d;
	logic [ROW_W-1:0]  cur_row_q, cur_row_d;
	logic [LINE_W-1:0] top_q, top_d;
	logic [LH_W-1:0]   held_q, held_d;
	logic [LINE_W-1:0] view_q, view_d;
	logic [ADDR_W-1:0] init_q, init_d;
	logic              out_valid_q, out_valid_d;

	// Latched item and working registers
	logic [3:0]        op_q;
	logic [7:0]        ch_q;
	logic [31:0]       fg_q, bg_q;
	logic [7:0]        attr_q;
	logic [6:0]        carg_q;
	logic [4:0]        rarg_q;
	logic signed [9:0] delta_q;
	logic [LINE_W-1:0] line_q, line_d;
	logic [CC_W-1:0]   walk_q, walk_d, end_q, end_d;
	logic [31:0]       fbg_q, fbg_d;
	logic [LH_W-1:0]   cls_q, cls_d;
	logic              hit_q, hit_d;
	logic              load_out;

	// Result registers
	tsb_pkg::tsb_cell_t res_cell_q;
	logic [7:0]        res_col_q;
	logic [4:0]        res_row_q;
	logic [7:0]        res_view_q;

	// Memory ports
	logic               wr_en, rd_en;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	tsb_pkg::tsb_cell_t wr_data, rd_data, blank_cell;

	// Derived values
	logic [8:0]        cols_ext;
	logic [6:0]        rows_ext;
	logic [CC_W-1:0]   cols;
	logic [RC_W-1:0]   rows;
	logic [LINE_W-1:0] cur_line;
	logic [RC_W:0]     row_next;
	logic [CC_W:0]     col_next, walk_next;
	logic signed [SW-1:0] v_sum, v_max;

	tsb_cell_ram #(
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Active sizes, zero acts as one and large values saturate
	always_comb begin
		if (columns_q == 8'd0) begin
			cols_ext = 9'd1;
		end else if ({1'b0, columns_q} > 9'(MAX_COLUMNS)) begin
			cols_ext = 9'(MAX_COLUMNS);
		end else begin
			cols_ext = {1'b0, columns_q};
		end
		if (rows_q == 6'd0) begin
			rows_ext = 7'd1;
		end else if ({1'b0, rows_q} > 7'(MAX_SCREEN_ROWS)) begin
			rows_ext = 7'(MAX_SCREEN_ROWS);
		end else begin
			rows_ext = {1'b0, rows_q};
		end
	end
	assign cols = CC_W'(cols_ext);
	assign rows = RC_W'(rows_ext);

	assign cur_line  = wrap_line(WW'(top_q) + WW'(cur_row_q));
	assign row_next  = (RC_W+1)'(cur_row_q) + (RC_W+1)'(1);
	assign col_next  = (CC_W+1)'(cur_col_q) + (CC_W+1)'(1);
	assign walk_next = (CC_W+1)'(walk_q) + (CC_W+1)'(1);

	// Scroll arithmetic
	assign v_sum = SW'(view_q) + SW'(delta_q);
	assign v_max = SW'(held_q) - SW'(rows);

	assign blank_cell = '{bg: dbg_q, fg: dfg_q, attr: 8'd0, ch: tsb_pkg::BLANK_CHAR};

	assign in_ready = (state_q == tsb_pkg::ST_IDLE);
	assign load_out = (state_q == tsb_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// Sequencer: next state, memory port and working registers
	always_comb begin
		state_d     = state_q;
		ret_d       = ret_q;
		cur_col_d   = cur_col_q;
		cur_row_d   = cur_row_q;
		top_d       = top_q;
		held_d      = held_q;
		view_d      = view_q;
		init_d      = init_q;
		line_d      = line_q;
		walk_d      = walk_q;
		end_d       = end_q;
		fbg_d       = fbg_q;
		cls_d       = cls_q;
		hit_d       = hit_q;
		out_valid_d = out_valid_q && !out_ready;
		wr_en       = 1'b0;
		wr_addr     = {cur_line, COL_W'(cur_col_q)};
		wr_data     = blank_cell;
		rd_en       = 1'b0;
		rd_addr     = {line_q, COL_W'(carg_q)};

		case (state_q)
			tsb_pkg::ST_INIT: begin
				// post-reset sweep with the reset default colours
				wr_en   = 1'b1;
				wr_addr = init_q;
				wr_data = '{bg: tsb_pkg::BACKGROUND_RESET, fg: tsb_pkg::FOREGROUND_RESET,
					attr: 8'd0, ch: tsb_pkg::BLANK_CHAR};
				init_d  = init_q + ADDR_W'(1);
				if (init_q == {ADDR_W{1'b1}}) begin
					state_d = tsb_pkg::ST_IDLE;
				end
			end

			tsb_pkg::ST_IDLE: begin
				hit_d = 1'b0;
				if (in_valid) begin
					state_d = tsb_pkg::ST_DECODE;
				end
			end

			tsb_pkg::ST_DECODE: begin
				state_d = tsb_pkg::ST_DONE;
				ret_d   = tsb_pkg::ST_DONE;
				case (tsb_pkg::tsb_op_t'(op_q))
					tsb_pkg::OP_PUT: begin
						if (cur_col_q >= cols) begin
							ret_d   = tsb_pkg::ST_PUT;
							state_d = tsb_pkg::ST_NEWLINE;
						end else begin
							wr_en     = 1'b1;
							wr_data   = '{bg: bg_q, fg: fg_q, attr: attr_q, ch: ch_q};
							cur_col_d = CC_W'(col_next);
						end
					end
					tsb_pkg::OP_BACKSPACE: begin
						if (cur_col_q != '0) begin
							cur_col_d = cur_col_q - CC_W'(1);
							wr_en     = 1'b1;
							wr_addr   = {cur_line, COL_W'(cur_col_q - CC_W'(1))};
						end
					end
					tsb_pkg::OP_NEWLINE: begin
						state_d = tsb_pkg::ST_NEWLINE;
					end
					tsb_pkg::OP_SETCURSOR: begin
						if (9'(carg_q) < 9'(cols)) begin
							cur_col_d = CC_W'(carg_q);
						end
						if (7'(rarg_q) < 7'(rows)) begin
							cur_row_d = ROW_W'(rarg_q);
						end
					end
					tsb_pkg::OP_CLRSCREEN: begin
						cls_d   = '0;
						state_d = tsb_pkg::ST_CLS;
					end
					tsb_pkg::OP_CLRFROM: begin
						if (cur_col_q < cols) begin
							line_d  = cur_line;
							walk_d  = cur_col_q;
							end_d   = cols;
							fbg_d   = dbg_q;
							state_d = tsb_pkg::ST_FILL;
						end
					end
					tsb_pkg::OP_CLRTO: begin
						line_d  = cur_line;
						walk_d  = '0;
						end_d   = (col_next < (CC_W+1)'(cols)) ? CC_W'(col_next) : cols;
						fbg_d   = dbg_q;
						state_d = tsb_pkg::ST_FILL;
					end
					tsb_pkg::OP_CLRLINE: begin
						line_d  = cur_line;
						walk_d  = '0;
						end_d   = cols;
						fbg_d   = dbg_q;
						state_d = tsb_pkg::ST_FILL;
					end
					tsb_pkg::OP_SCROLL: begin
						// clamp to 0 .. max(0, lines_held - rows)
						if (v_sum < 0) begin
							view_d = '0;
						end else if (v_max < 0) begin
							view_d = '0;
						end else if (v_sum > v_max) begin
							view_d = LINE_W'(v_max);
						end else begin
							view_d = LINE_W'(v_sum);
						end
					end
					tsb_pkg::OP_READ: begin
						if ((9'(carg_q) < 9'(cols)) && (7'(rarg_q) < 7'(rows))) begin
							hit_d   = 1'b1;
							line_d  = wrap_line(WW'(top_q) + WW'(rarg_q));
							state_d = tsb_pkg::ST_VIEW;
						end
					end
					default: begin
					end
				endcase
			end

			tsb_pkg::ST_NEWLINE: begin
				cur_col_d = '0;
				if (row_next >= (RC_W+1)'(rows)) begin
					// scroll: recycle the line below the screen
					line_d  = wrap_line(WW'(top_q) + WW'(rows));
					walk_d  = '0;
					end_d   = cols;
					fbg_d   = bg_q;
					top_d   = wrap_line(WW'(top_q) + WW'(1));
					if (held_q < LH_W'(HISTORY_LINES)) begin
						held_d = held_q + LH_W'(1);
					end
					state_d = tsb_pkg::ST_FILL;
				end else begin
					cur_row_d = ROW_W'(row_next);
					state_d   = ret_q;
				end
			end

			tsb_pkg::ST_FILL: begin
				// one blank cell per cycle
				wr_en   = 1'b1;
				wr_addr = {line_q, COL_W'(walk_q)};
				wr_data = '{bg: fbg_q, fg: dfg_q, attr: 8'd0, ch: tsb_pkg::BLANK_CHAR};
				walk_d  = CC_W'(walk_next);
				if (walk_next >= (CC_W+1)'(end_q)) begin
					state_d = ret_q;
				end
			end

			tsb_pkg::ST_PUT: begin
				wr_en     = 1'b1;
				wr_data   = '{bg: bg_q, fg: fg_q, attr: attr_q, ch: ch_q};
				cur_col_d = CC_W'(col_next);
				state_d   = tsb_pkg::ST_DONE;
			end

			tsb_pkg::ST_CLS: begin
				if (cls_q < held_q) begin
					line_d  = wrap_line(WW'(top_q) + WW'(cls_q));
					walk_d  = '0;
					end_d   = cols;
					fbg_d   = dbg_q;
					cls_d   = cls_q + LH_W'(1);
					ret_d   = tsb_pkg::ST_CLS;
					state_d = tsb_pkg::ST_FILL;
				end else begin
					cur_col_d = '0;
					cur_row_d = '0;
					state_d   = tsb_pkg::ST_DONE;
				end
			end

			tsb_pkg::ST_VIEW: begin
				// step back by the view offset around the ring
				rd_en   = 1'b1;
				rd_addr = {wrap_line(WW'(line_q) + WW'(HISTORY_LINES) - WW'(view_q)),
					COL_W'(carg_q)};
				state_d = tsb_pkg::ST_DONE;
			end

			tsb_pkg::ST_DONE: begin
				if (load_out) begin
					out_valid_d = 1'b1;
					state_d     = tsb_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = tsb_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsb_pkg::ST_INIT;
			ret_q       <= tsb_pkg::ST_DONE;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			top_q       <= '0;
			held_q      <= LH_W'(tsb_pkg::LINES_HELD_RESET);
			view_q      <= '0;
			init_q      <= '0;
			out_valid_q <= 1'b0;
			columns_q   <= tsb_pkg::COLUMNS_RESET;
			rows_q      <= tsb_pkg::ROWS_RESET;
			dfg_q       <= tsb_pkg::FOREGROUND_RESET;
			dbg_q       <= tsb_pkg::BACKGROUND_RESET;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			cur_col_q   <= cur_col_d;
			cur_row_q   <= cur_row_d;
			top_q       <= top_d;
			held_q      <= held_d;
			view_q      <= view_d;
			init_q      <= init_d;
			out_valid_q <= out_valid_d;
			if (cfg_write_en) begin
				case (tsb_pkg::tsb_cfg_t'(cfg_index))
					tsb_pkg::CFG_COLUMNS:    columns_q <= cfg_data[7:0];
					tsb_pkg::CFG_ROWS:       rows_q    <= cfg_data[5:0];
					tsb_pkg::CFG_FOREGROUND: dfg_q     <= cfg_data;
					tsb_pkg::CFG_BACKGROUND: dbg_q     <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// Item latch, working and result registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= op;
			ch_q    <= char_code;
			fg_q    <= fore_colour;
			bg_q    <= back_colour;
			attr_q  <= attr_flags;
			carg_q  <= column_arg;
			rarg_q  <= row_arg;
			delta_q <= scroll_delta;
		end
		line_q <= line_d;
		walk_q <= walk_d;
		end_q  <= end_d;
		fbg_q  <= fbg_d;
		cls_q  <= cls_d;
		hit_q  <= hit_d;
		if (load_out) begin
			res_cell_q <= hit_q ? rd_data : blank_cell;
			res_col_q  <= 8'(cur_col_q);
			res_row_q  <= 5'(cur_row_q);
			res_view_q <= 8'(view_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign cell_char       = res_cell_q.ch;
	assign cell_fore       = res_cell_q.fg;
	assign cell_back       = res_cell_q.bg;
	assign cell_attr       = res_cell_q.attr;
	assign cursor_column   = res_col_q;
	assign cursor_line     = res_row_q;
	assign view_offset_out = res_view_q;

`ifndef SYNTHESIS
	// history count never exceeds the ring
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= LH_W'(HISTORY_LINES))
		else $error("lines held beyond ring size");

	// top line stays inside the ring
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q < LINE_W'(HISTORY_LINES) || LINE_W'(HISTORY_LINES) == '0)
		else $error("top line outside ring");

	// an accepted item blocks the input on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accept");

	// no cell write while waiting for an item
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tsb_pkg::ST_IDLE |-> !wr_en)
		else $error("cell write while idle");

	// view offset stays within the held history
	a_view_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LH_W'(view_q) < held_q)
		else $error("view offset beyond history");
`endif

endmodule
